// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by glu_ctrl, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define GLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define GLU_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/glu_pkg.sv -----
// ----------------------------------------------------------------------------
// glu_pkg
// Shared constants, controller states and command/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MLD,
        ST_MUL,
        ST_OUT
    } glu_state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_finish;
        logic div_step;
        logic mul_load;
        logic mul_step;
        logic write_out;
    } glu_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic zero_op;
        logic mode_lcm;
    } glu_stat_t;

endpackage

// ----- sv/glu_dpath.sv -----
// ----------------------------------------------------------------------------
// glu_dpath
// Operand registers, binary gcd step, bit-serial divider and multiplier,
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glu_dpath
    import glu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  glu_cmd_t              cmd,
    output glu_stat_t             stat,
    input  logic                  mode,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic [DATA_WIDTH:0]   result,
    output logic                  overflow
);

    localparam int KW = $clog2(DATA_WIDTH);
    localparam int DW = DATA_WIDTH;

    logic [DW-1:0]   ua_reg, ua_next;
    logic [DW-1:0]   ub_reg, ub_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [2*DW-1:0] prod_reg, prod_next;
    logic            mode_reg, mode_next;
    logic            neg_reg, neg_next;
    logic [DW:0]     result_reg, result_next;
    logic            overflow_reg, overflow_next;

    logic [DW:0]     div_shift;
    logic [DW:0]     div_trial;
    logic [DW:0]     mul_sum;
    logic [DW-1:0]   prod_lo;
    logic [DW-1:0]   limit;
    logic [DW-1:0]   lcm_val;
    logic            lcm_ovf;

    assign stat.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign stat.zero_op  = (ua_reg == '0) || (ub_reg == '0);
    assign stat.mode_lcm = mode_reg;

    assign div_shift = {rem_reg, x_reg[DW-1]};
    assign div_trial = div_shift - {1'b0, y_reg};
    assign mul_sum   = {1'b0, prod_reg[2*DW-1:DW]} + (prod_reg[0] ? {1'b0, ub_reg} : '0);

    assign prod_lo = prod_reg[DW-1:0];
    assign limit   = neg_reg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign lcm_ovf = (prod_reg[2*DW-1:DW] != '0) || (prod_lo > limit);
    assign lcm_val = neg_reg ? (~prod_lo + 1'b1) : prod_lo;

    always_comb
    begin
        ua_next       = ua_reg;
        ub_next       = ub_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        rem_next      = rem_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        mode_next     = mode_reg;
        neg_next      = neg_reg;
        result_next   = result_reg;
        overflow_next = overflow_reg;

        if (cmd.load)
        begin
            ua_next   = operand_a[DW-1] ? (~operand_a + 1'b1) : operand_a;
            ub_next   = operand_b[DW-1] ? (~operand_b + 1'b1) : operand_b;
            x_next    = ua_next;
            y_next    = ub_next;
            k_next    = '0;
            mode_next = mode;
            neg_next  = operand_a[DW-1] ^ operand_b[DW-1];
        end

        if (cmd.gcd_step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = (x_reg - y_reg) >> 1;
            end
            else
            begin
                y_next = (y_reg - x_reg) >> 1;
            end
        end

        if (cmd.gcd_finish)
        begin
            y_next   = (x_reg | y_reg) << k_reg;
            x_next   = ua_reg;
            rem_next = '0;
        end

        if (cmd.div_step)
        begin
            if (!div_trial[DW])
            begin
                rem_next = div_trial[DW-1:0];
                x_next   = {x_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = div_shift[DW-1:0];
                x_next   = {x_reg[DW-2:0], 1'b0};
            end
        end

        if (cmd.mul_load)
        begin
            prod_next = {{DW{1'b0}}, x_reg};
        end

        if (cmd.mul_step)
        begin
            prod_next = {mul_sum, prod_reg[DW-1:1]};
        end

        if (cmd.write_out)
        begin
            priority if (!mode_reg)
            begin
                result_next   = {1'b0, y_reg};
                overflow_next = 1'b0;
            end
            else if (stat.zero_op)
            begin
                result_next   = '0;
                overflow_next = 1'b0;
            end
            else
            begin
                result_next   = {lcm_val[DW-1], lcm_val};
                overflow_next = lcm_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        mode_reg     <= mode_next;
        neg_reg      <= neg_next;
        result_reg   <= result_next;
        overflow_reg <= overflow_next;
    end

    assign result   = result_reg;
    assign overflow = overflow_reg;

endmodule

// ----- sv/glu_ctrl.sv -----
// ----------------------------------------------------------------------------
// glu_ctrl
// Sequencer: steps the gcd loop, the divide and the multiply, and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module glu_ctrl
    import glu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  glu_stat_t stat,
    output glu_cmd_t  cmd
);

    localparam int KW = $clog2(DATA_WIDTH);

    glu_state_t    state_reg, state_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;
    logic          cnt_last;

    assign out_free = !out_valid_reg || out_ready;
    assign cnt_last = (cnt_reg == KW'(DATA_WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.gcd_finish = 1'b1;
                    cnt_next       = '0;
                    state_next     = (stat.mode_lcm && !stat.zero_op) ? ST_DIV : ST_OUT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_MLD;
                end
            end
            ST_MLD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.write_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `GLU_ASSERT(a_write_when_free, cmd.write_out |-> out_free, "result overwritten while pending")
    `GLU_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
    `GLU_ASSERT(a_div_only_lcm, cmd.div_step |-> (stat.mode_lcm && !stat.zero_op), "divide out of mode")
    `GLU_NEVER(a_gcd_step_done, cmd.gcd_step && stat.gcd_done, "gcd stepped past its end")

endmodule

// ----- sv/gcd_lcm_unit.sv -----
// Computes gcd or signed lcm of two DATA_WIDTH-bit operands, one transaction at a time.
// The gcd uses a binary subtract-and-shift loop removing at least one operand bit per cycle,
// so the length of the gcd loop is set by the bit lengths of the operand magnitudes. Lcm
// mode adds a bit-serial restoring divide, a multiplier load state and a shift-add multiply.
// Either operand zero in lcm mode skips the divide and the multiply. A new transaction is
// taken once the previous result has been written to the output register, even if it is
// still waiting there; a result that has not been taken when the next one is ready holds
// the unit until out_ready frees the output register.
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Top level: greatest common divisor / least common multiple unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_lcm_unit
    import glu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH:0]   result,
    output logic                  overflow
);

    glu_cmd_t  cmd;
    glu_stat_t stat;

    glu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    glu_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (mode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .result    (result),
        .overflow  (overflow)
    );

endmodule
